FILE: sv/tgm_pkg.sv
// shared types and constants for the greedy threshold matching counter
// no dependencies; imported by tgm_cell, tgm_chain and the top level
`timescale 1ns / 1ps

package tgm_pkg;

    localparam int VAL_W   = 8;
    localparam int MATCH_W = 6;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_POP,
        OP_CLEAR
    } t_op;

    typedef enum logic {
        ST_LOAD,
        ST_MATCH
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] val;
    } t_head;

endpackage

FILE: sv/greedy_threshold_matching_count.sv
// top level: greedy threshold matching counter with item and slot sort chains
// depends on tgm_pkg and tgm_chain
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  i_item_weight, i_slot_capacity, i_last_entry
//  result    out        o_valid / i_ready  o_match_count
//
// loading takes one entry per cycle while no pass runs; each entry is inserted into both chains at once
// entries past MAX_ENTRIES are dropped, a dropped closing entry still starts the pass
// the pass pops the smallest slot every cycle until either chain runs empty, then hands
// the count to the output register; input is held off during the pass
// the pass waits at its end while the output register still holds an untaken result
// reset is synchronous, active low, and empties both chains
`timescale 1ns / 1ps

module greedy_threshold_matching_count #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tgm_pkg::VAL_W-1:0]   i_item_weight,
    input  logic [tgm_pkg::VAL_W-1:0]   i_slot_capacity,
    input  logic                        i_last_entry,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tgm_pkg::MATCH_W-1:0] o_match_count
);
    import tgm_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_entry_count;
    logic [CNT_W-1:0]   n_entry_count;
    logic [MATCH_W-1:0] r_match_count;
    logic [MATCH_W-1:0] n_match_count;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [MATCH_W-1:0] r_out_count;
    logic [MATCH_W-1:0] n_out_count;

    t_op                w_item_op;
    t_op                w_slot_op;
    t_head              w_item_head;
    t_head              w_slot_head;
    logic               w_in_xfer;
    logic               w_done;
    logic               w_out_free;
    logic               w_room;

    assign o_ready       = (r_state == ST_LOAD);
    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_done     = !w_item_head.valid || !w_slot_head.valid;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_room     = (r_entry_count < CNT_W'(MAX_ENTRIES));

    tgm_chain #(
        .DEPTH (MAX_ENTRIES)
    ) u_item_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_item_op),
        .i_key   (i_item_weight),
        .o_head  (w_item_head)
    );

    tgm_chain #(
        .DEPTH (MAX_ENTRIES)
    ) u_slot_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_slot_op),
        .i_key   (i_slot_capacity),
        .o_head  (w_slot_head)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid && i_last_entry) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (w_done && w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        w_item_op     = OP_HOLD;
        w_slot_op     = OP_HOLD;
        n_entry_count = r_entry_count;
        n_match_count = r_match_count;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_count   = r_out_count;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid && w_room) begin
                    w_item_op     = OP_LOAD;
                    w_slot_op     = OP_LOAD;
                    n_entry_count = r_entry_count + CNT_W'(1);
                end
            end
            ST_MATCH: begin
                if (w_done) begin
                    if (w_out_free) begin
                        n_out_valid   = 1'b1;
                        n_out_count   = r_match_count;
                        w_item_op     = OP_CLEAR;
                        w_slot_op     = OP_CLEAR;
                        n_entry_count = '0;
                        n_match_count = '0;
                    end
                end else if (w_item_head.val <= w_slot_head.val) begin
                    w_item_op     = OP_POP;
                    w_slot_op     = OP_POP;
                    n_match_count = r_match_count + MATCH_W'(1);
                end else begin
                    w_slot_op = OP_POP;
                end
            end
            default: begin
                w_item_op = OP_HOLD;
                w_slot_op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_entry_count <= '0;
            r_match_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_match_count <= n_match_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count <= n_out_count;
    end

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past capacity");

    a_close_starts_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_entry) |=> (r_state == ST_MATCH))
        else $error("closing transfer did not start the pass");

    a_pass_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MATCH && n_state == ST_LOAD) |=> (o_valid && r_entry_count == '0))
        else $error("pass ended without a result");

    a_pass_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_entry) |=> (r_entry_count != '0))
        else $error("pass started with no entries");

endmodule

FILE: sv/tgm_cell.sv
// one cell of a sorted insertion chain: holds one value and its valid bit
// depends on tgm_pkg
`timescale 1ns / 1ps

module tgm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tgm_pkg::t_op              i_op,
    input  logic [tgm_pkg::VAL_W-1:0] i_key,
    input  logic                      i_left_stays,
    input  logic                      i_left_valid,
    input  logic [tgm_pkg::VAL_W-1:0] i_left_val,
    input  logic                      i_right_valid,
    input  logic [tgm_pkg::VAL_W-1:0] i_right_val,
    output logic                      o_valid,
    output logic [tgm_pkg::VAL_W-1:0] o_val,
    output logic                      o_stays
);
    import tgm_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;

    assign o_valid = r_valid;
    assign o_val   = r_val;
    assign o_stays = r_valid && (r_val <= i_key);

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        unique case (i_op)
            OP_LOAD: begin
                if (o_stays) begin
                    n_valid = r_valid;
                    n_val   = r_val;
                end else if (i_left_stays) begin
                    n_valid = 1'b1;
                    n_val   = i_key;
                end else begin
                    n_valid = i_left_valid;
                    n_val   = i_left_val;
                end
            end
            OP_POP: begin
                n_valid = i_right_valid;
                n_val   = i_right_val;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
                n_val   = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: sv/tgm_chain.sv
// row of tgm_cell kept in ascending order, smallest value at the head
// depends on tgm_pkg and tgm_cell
`timescale 1ns / 1ps

module tgm_chain #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tgm_pkg::t_op              i_op,
    input  logic [tgm_pkg::VAL_W-1:0] i_key,
    output tgm_pkg::t_head            o_head
);
    import tgm_pkg::*;

    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_stays;
    logic [VAL_W-1:0] w_val [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             w_left_stays;
        logic             w_left_valid;
        logic [VAL_W-1:0] w_left_val;
        logic             w_right_valid;
        logic [VAL_W-1:0] w_right_val;

        if (g == 0) begin : g_first
            assign w_left_stays = 1'b1;
            assign w_left_valid = 1'b0;
            assign w_left_val   = '0;
        end else begin : g_mid
            assign w_left_stays = w_stays[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_val   = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_valid = 1'b0;
            assign w_right_val   = '0;
        end else begin : g_inner
            assign w_right_valid = w_valid[g+1];
            assign w_right_val   = w_val[g+1];
        end

        tgm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (i_op),
            .i_key         (i_key),
            .i_left_stays  (w_left_stays),
            .i_left_valid  (w_left_valid),
            .i_left_val    (w_left_val),
            .i_right_valid (w_right_valid),
            .i_right_val   (w_right_val),
            .o_valid       (w_valid[g]),
            .o_val         (w_val[g]),
            .o_stays       (w_stays[g])
        );
    end

    assign o_head.valid = w_valid[0];
    assign o_head.val   = w_val[0];

    // occupied cells form a sorted prefix
    for (genvar g = 0; g < DEPTH - 1; g++) begin : g_chk
        a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_valid[g+1] |-> w_valid[g])
            else $error("chain hole below an occupied cell");
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_valid[g+1] |-> (w_val[g] <= w_val[g+1]))
            else $error("chain out of order");
    end

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_CLEAR) |=> (w_valid == '0))
        else $error("chain not empty after clear");

endmodule

FILE: dv/tb_top.sv
// testbench for greedy_threshold_matching_count: directed table, then random sets
// checks every match count against the bench's greedy predictor or a row's typed count
// depends on tgm_pkg and the greedy_threshold_matching_count rtl
`timescale 1ns / 1ps

module tb_top;

    import tgm_pkg::*;

    localparam int MAX_ENTRIES  = 32;
    localparam int RANDOM_ITEMS = 1100;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_ROWS     = 20;
    localparam int NO_PIN       = -1;

    typedef struct {
        int wt;
        int cap;
        int last;
        int reps;
        int pin;
    } t_row;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [VAL_W-1:0]   i_item_weight   = '0;
    logic [VAL_W-1:0]   i_slot_capacity = '0;
    logic               i_last_entry    = 1'b0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic [MATCH_W-1:0] o_match_count;

    // typed count for the closing entry of a directed row, sent along with the payload
    int pinned_count = NO_PIN;

    logic [VAL_W-1:0]   held_wt  [MAX_ENTRIES];
    logic [VAL_W-1:0]   held_cap [MAX_ENTRIES];
    int                 held_n = 0;
    logic [MATCH_W-1:0] expected_counts [$];

    t_row dir_rows [NUM_ROWS];
    int   failures   = 0;
    int   burst_left = 0;
    int   random_sent = 0;
    int   hold_asks  = 0;
    int   holds_done = 0;

    greedy_threshold_matching_count #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_item_weight   (i_item_weight),
        .i_slot_capacity (i_slot_capacity),
        .i_last_entry    (i_last_entry),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_match_count   (o_match_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // greedy pass: lightest free item against smallest free slot, ties to the lowest index
    function automatic int count_matches(input int n);
        bit item_taken [MAX_ENTRIES];
        bit slot_taken [MAX_ENTRIES];
        int count;
        int it;
        int sl;
        bit can_hold;
        bit done;
        count = 0;
        done  = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            item_taken[i] = 1'b0;
            slot_taken[i] = 1'b0;
        end
        while (!done) begin
            it = -1;
            for (int i = 0; i < n; i++) begin
                if (!item_taken[i] && (it < 0 || held_wt[i] < held_wt[it])) begin
                    it = i;
                end
            end
            if (it < 0) begin
                done = 1'b1;
            end else begin
                can_hold = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!slot_taken[i] && held_cap[i] >= held_wt[it]) begin
                        can_hold = 1'b1;
                    end
                end
                if (!can_hold) begin
                    done = 1'b1;
                end else begin
                    sl = -1;
                    for (int i = 0; i < n; i++) begin
                        if (!slot_taken[i] && (sl < 0 || held_cap[i] < held_cap[sl])) begin
                            sl = i;
                        end
                    end
                    slot_taken[sl] = 1'b1;
                    if (held_wt[it] <= held_cap[sl]) begin
                        item_taken[it] = 1'b1;
                        count++;
                    end
                end
            end
        end
        return count;
    endfunction

    // result check, then prediction for the input transfer of the same edge
    always @(posedge i_clk) begin
        logic [MATCH_W-1:0] want;
        int                 cnt;
        if (i_rst_n) begin
            if ($isunknown(o_valid) || $isunknown(o_ready)) begin
                note_failure("handshake output unknown");
            end
            if (o_valid && i_ready) begin
                if (expected_counts.size() == 0) begin
                    note_failure($sformatf("unexpected match count %0d", o_match_count));
                end else begin
                    want = expected_counts.pop_front();
                    if (o_match_count !== want) begin
                        note_failure($sformatf("match_count expected %0d got %0d",
                                               want, o_match_count));
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (held_n < MAX_ENTRIES) begin
                    held_wt[held_n]  = i_item_weight;
                    held_cap[held_n] = i_slot_capacity;
                    held_n++;
                end
                if (i_last_entry) begin
                    cnt = count_matches(held_n);
                    if (pinned_count >= 0) begin
                        cnt = pinned_count;
                    end
                    expected_counts.push_back(cnt[MATCH_W-1:0]);
                    held_n = 0;
                end
            end
        end
    end

    // sender: bursts of random length separated by random gaps
    task automatic send_entry(input logic [VAL_W-1:0] w, input logic [VAL_W-1:0] c,
                              input logic last, input int pin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_valid         <= 1'b1;
        i_item_weight   <= w;
        i_slot_capacity <= c;
        i_last_entry    <= last;
        pinned_count    <= pin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input int mode);
        case (mode)
            0: return VAL_W'($urandom_range(0, 255));
            1: return VAL_W'($urandom_range(0, 7));
            2: return ($urandom_range(0, 1) == 1) ? VAL_W'($urandom_range(252, 255))
                                                   : VAL_W'($urandom_range(0, 3));
            default: return VAL_W'(100 + $urandom_range(0, 20));
        endcase
    endfunction

    task automatic send_random_set();
        int len;
        int mode;
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            send_entry(pick_value(mode), pick_value(mode), k == len - 1, NO_PIN);
            random_sent++;
        end
    endtask

    // receiver: its own stall pattern, plus long hold-offs on request
    initial begin
        int pick;
        int len;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holds_done < hold_asks) begin
                holds_done++;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 9);
                len  = (pick < 3) ? $urandom_range(1, 30) : $urandom_range(1, 20);
                for (int k = 0; k < len; k++) begin
                    if (pick < 3) begin
                        i_ready <= 1'b1;
                    end else if (pick < 7) begin
                        i_ready <= 1'($urandom_range(0, 1));
                    end else begin
                        i_ready <= (len - k > 6) ? 1'b1 : 1'b0;
                    end
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        bit mid_hold;
        mid_hold = 1'b0;
        // weight, capacity, last, repeats, typed count (NO_PIN: predictor)
        dir_rows = '{
            '{0,   0,   1, 1,  1},
            '{255, 0,   1, 1,  0},
            '{0,   255, 1, 1,  1},
            '{255, 255, 1, 1,  1},
            '{255, 254, 1, 1,  0},
            '{10,  20,  0, 1,  NO_PIN},
            '{30,  5,   0, 1,  NO_PIN},
            '{20,  40,  1, 1,  NO_PIN},
            '{5,   3,   0, 1,  NO_PIN},
            '{9,   10,  1, 1,  NO_PIN},
            '{5,   5,   1, 40, 32},
            '{1,   1,   0, 32, NO_PIN},
            '{0,   255, 1, 1,  32},
            '{200, 100, 0, 32, NO_PIN},
            '{0,   0,   1, 1,  0},
            '{255, 255, 0, 31, NO_PIN},
            '{0,   0,   1, 1,  32},
            '{128, 127, 0, 1,  NO_PIN},
            '{127, 128, 0, 1,  NO_PIN},
            '{64,  64,  1, 1,  NO_PIN}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; a repeated row closes only on its final entry
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                send_entry(dir_rows[r].wt[VAL_W-1:0], dir_rows[r].cap[VAL_W-1:0],
                           dir_rows[r].last != 0 && k == dir_rows[r].reps - 1,
                           (k == dir_rows[r].reps - 1) ? dir_rows[r].pin : NO_PIN);
            end
        end

        hold_asks++;
        while (random_sent < RANDOM_ITEMS) begin
            if (!mid_hold && random_sent >= RANDOM_ITEMS / 2) begin
                mid_hold = 1'b1;
                hold_asks++;
            end
            send_random_set();
        end
        i_valid <= 1'b0;

        // let the checker record the final transfer before waiting on results
        @(posedge i_clk);
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
